// ----- design/swe_pkg.sv -----
// ----------------------------------------------------------------------------
// swe_pkg
// Shared types and constants for the sliding window extremum unit.
// ----------------------------------------------------------------------------
package swe_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int POS_W      = 16;
  localparam int WLEN_W     = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FIND_MINIMUM  = CFG_IDX_W'(1);

  typedef enum logic {
    CTL_EMPTY,
    CTL_FULL
  } ctl_state_e;

  typedef struct packed {
    logic step;
  } dp_cmd_t;

endpackage

// ----- design/swe_ctrl.sv -----
// ----------------------------------------------------------------------------
// swe_ctrl
// Handshake controller: tracks the result register and issues a step per item.
// ----------------------------------------------------------------------------
module swe_ctrl
  import swe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.step   = 1'b0;
    state_d      = state_q;
    unique case (state_q)
      CTL_EMPTY: begin
        in_ready_o = 1'b1;
        cmd_o.step = in_valid_i;
        if (in_valid_i) begin
          state_d = CTL_FULL;
        end
      end
      CTL_FULL: begin
        out_valid_o = 1'b1;
        // result register frees up in the same cycle it is taken
        in_ready_o  = out_ready_i;
        cmd_o.step  = in_valid_i && out_ready_i;
        if (out_ready_i && !in_valid_i) begin
          state_d = CTL_EMPTY;
        end
      end
      default: begin
        state_d = CTL_EMPTY;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_step_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> in_valid_i)
    else $error("step issued without an input item");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> out_valid_o)
    else $error("result not presented after step");

  a_full_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("pending result dropped");
`endif

endmodule

// ----- design/swe_datapath.sv -----
// ----------------------------------------------------------------------------
// swe_datapath
// Monotonic deque cells, config registers and the result register.
// ----------------------------------------------------------------------------
module swe_datapath
  import swe_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  input  logic                          cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          end_of_sequence_i,
  output logic signed [SAMPLE_BITS-1:0] window_extreme_o,
  output logic                          last_out_o
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [WLEN_W-1:0]  wlen_q;
  logic               find_min_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [POS_W-1:0]   pos_q;

  logic signed [SAMPLE_BITS-1:0] val_q [WINDOW_MAX];
  logic [POS_W-1:0]              posn_q [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] val_d [WINDOW_MAX];
  logic [POS_W-1:0]              posn_d [WINDOW_MAX];

  logic signed [SAMPLE_BITS-1:0] ext_val [WINDOW_MAX+1];
  logic [POS_W-1:0]              ext_pos [WINDOW_MAX+1];

  logic [WINDOW_MAX-1:0] stay, keep, expd;
  logic                  tail_kept;
  logic [POS_W-1:0]      age [WINDOW_MAX];
  logic [POS_W-1:0]      w_eff, wlen_ext;
  logic [CNT_W-1:0]      k, e;
  logic [CNT_W:0]        src  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] extreme_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q     <= WLEN_RESET;
      find_min_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: wlen_q     <= cfg_data_i[WLEN_W-1:0];
        REG_FIND_MINIMUM:  find_min_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wlen_ext = POS_W'(wlen_q);
    if (wlen_ext == '0) begin
      w_eff = POS_W'(1);
    end else if (wlen_ext > POS_W'(WINDOW_MAX)) begin
      w_eff = POS_W'(WINDOW_MAX);
    end else begin
      w_eff = wlen_ext;
    end
  end

  // back entries drop out while the new sample ties or beats them, stopping
  // at the first one from the back that holds; everything in front of it stays
  // (after a mode change the cells need not be monotonic)
  always_comb begin
    tail_kept = 1'b0;
    for (int i = WINDOW_MAX - 1; i >= 0; i--) begin
      stay[i] = (CNT_W'(i) < count_q) &&
                !(find_min_q ? (sample_i <= val_q[i]) : (sample_i >= val_q[i]));
      tail_kept = tail_kept | stay[i];
      keep[i]   = tail_kept;
    end
    // front entries too old for the window expire
    for (int i = 0; i < WINDOW_MAX; i++) begin
      age[i]  = pos_q - posn_q[i];
      expd[i] = keep[i] && (age[i] >= w_eff);
    end
    k = CNT_W'($countones(keep));
    e = CNT_W'($countones(expd));

    for (int j = 0; j < WINDOW_MAX; j++) begin
      if (CNT_W'(j) < k) begin
        ext_val[j] = val_q[j];
        ext_pos[j] = posn_q[j];
      end else begin
        ext_val[j] = sample_i;
        ext_pos[j] = pos_q;
      end
    end
    ext_val[WINDOW_MAX] = sample_i;
    ext_pos[WINDOW_MAX] = pos_q;

    // compact toward the front by the number of expired entries
    for (int i = 0; i < WINDOW_MAX; i++) begin
      src[i] = (CNT_W + 1)'(i) + {1'b0, e};
      if (src[i] > (CNT_W + 1)'(WINDOW_MAX)) begin
        val_d[i]  = sample_i;
        posn_d[i] = pos_q;
      end else begin
        val_d[i]  = ext_val[src[i][CNT_W-1:0]];
        posn_d[i] = ext_pos[src[i][CNT_W-1:0]];
      end
    end

    count_d   = k + CNT_W'(1) - e;
    extreme_d = ext_val[e];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
    end else if (cmd_i.step) begin
      if (end_of_sequence_i) begin
        count_q <= '0;
        pos_q   <= '0;
      end else begin
        count_q <= count_d;
        pos_q   <= pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        val_q[i]  <= val_d[i];
        posn_q[i] <= posn_d[i];
      end
      window_extreme_o <= extreme_d;
      last_out_o       <= end_of_sequence_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_MAX))
    else $error("deque count beyond window maximum");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && end_of_sequence_i) |=> (count_q == '0 && pos_q == '0))
    else $error("deque not cleared after end of sequence");

  a_step_holds_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !end_of_sequence_i) |=>
      (count_q != '0 && pos_q == $past(pos_q) + POS_W'(1)))
    else $error("deque empty or position off after step");
`endif

endmodule

// ----- design/sliding_window_extremum_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_extremum_unit
// Running window maximum or minimum over a signed sample stream.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   sample_i, end_of_sequence_i
// out       output     out_valid_o / out_ready_i window_extreme_o, last_out_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle while results drain: all deque cells compare and compact
// combinationally, and the result lands in the output register on the
// accepting edge. the result register is freed in the cycle its item is taken,
// so a stalled output holds the input back only while that result waits.
// reset clears the deque count, position and config; cells need no clearing.
// ----------------------------------------------------------------------------
module sliding_window_extremum_unit
  import swe_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          end_of_sequence_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] window_extreme_o,
  output logic                          last_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  swe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  swe_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .window_extreme_o  (window_extreme_o),
    .last_out_o        (last_out_o)
  );

endmodule

// ----- bench/sliding_window_extremum_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sliding_window_extremum_unit_tb
// Self-checking bench for the sliding window maximum/minimum unit. A table of
// directed items and register writes runs first, then random phases with
// changing window settings, bursty input, a stalling output side and one long
// sequence at the widest window. Every result is checked in order against a
// deque-based model of the window held in the bench.
// ----------------------------------------------------------------------------
module sliding_window_extremum_unit_tb;
  import swe_pkg::*;

  localparam int SW           = SAMPLE_BITS_DEF;
  localparam int RANDOM_ITEMS = 1800;
  localparam int LONG_ITEMS   = 200;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 400;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);

  localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [SW-1:0]    sample;
    logic                    eos;
    bit                      known;
    logic signed [SW-1:0]    extreme;
  } directed_row_t;

  typedef struct {
    logic signed [SW-1:0] extreme;
    logic                 last;
  } window_result_t;

  typedef struct {
    logic signed [SW-1:0] value;
    logic [POS_W-1:0]     position;
  } candidate_t;

  localparam int DIRECTED_ROWS = 31;

  // typed results only where the window is obvious
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MAX,  1'b0, 1'b1, SAMPLE_MAX},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MIN,  1'b0, 1'b1, SAMPLE_MAX},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MIN,  1'b0, 1'b1, SAMPLE_MAX},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MIN,  1'b0, 1'b1, SAMPLE_MIN},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd0,      1'b1, 1'b1, 16'sd0},
    '{ROW_CFG,  REG_FIND_MINIMUM,  8'h01, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_WINDOW_LENGTH, 8'h00, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd100,    1'b0, 1'b1, 16'sd100},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MAX,  1'b0, 1'b1, SAMPLE_MAX},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, -16'sd5,     1'b1, 1'b1, -16'sd5},
    '{ROW_CFG,  REG_WINDOW_LENGTH, 8'hFF, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd10,     1'b0, 1'b1, 16'sd10},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd3,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd3,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd20,     1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MIN,  1'b0, 1'b1, SAMPLE_MIN},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MAX,  1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_SPARE,         8'hFF, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_FIND_MINIMUM,  8'hFE, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd50,     1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd50,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_WINDOW_LENGTH, 8'h02, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, -16'sd9,     1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, -16'sd9,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_WINDOW_LENGTH, 8'h10, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd1,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, 16'sd2,      1'b1, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_WINDOW_LENGTH, 8'h01, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MIN,  1'b1, 1'b1, SAMPLE_MIN},
    '{ROW_ITEM, REG_WINDOW_LENGTH, 8'h00, SAMPLE_MAX,  1'b1, 1'b1, SAMPLE_MAX},
    '{ROW_CFG,  REG_WINDOW_LENGTH, 8'h03, 16'sd0,      1'b0, 1'b0, 16'sd0}
  };

  logic [CFG_DATA_W-1:0] length_extremes [5] = '{8'd1, 8'd16, 8'd0, 8'hFF, 8'd17};

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic signed [SW-1:0]    in_sample = '0;
  logic                    in_eos    = 1'b0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [SW-1:0]    window_extreme;
  logic                    last_out;
  logic                    cfg_ready;

  // bench copy of the window state and settings
  candidate_t            candidates [$];
  logic [POS_W-1:0]      next_position = '0;
  logic [WLEN_W-1:0]     window_setting = WLEN_RESET;
  logic                  minimum_mode = 1'b0;

  window_result_t        awaited_extremes [$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;

  // output side stall control
  bit                    hold_req = 1'b0;
  bit                    steady_drain = 1'b0;
  int                    hold_left = 0;
  int                    stall_left = 0;
  logic [15:0]           stall_pattern = '0;

  sliding_window_extremum_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .sample_i          (in_sample),
    .end_of_sequence_i (in_eos),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .window_extreme_o  (window_extreme),
    .last_out_o        (last_out),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // push one sample through the window and return the extreme it leaves at the front
  function automatic logic signed [SW-1:0] track_extreme(input logic signed [SW-1:0] s,
                                                          input logic eos);
    int unsigned         span;
    logic [POS_W-1:0]    age;
    logic signed [SW-1:0] front;
    bit                  beaten;
    span = (window_setting == 0) ? 1 :
           (window_setting > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(window_setting);
    beaten = 1'b1;
    while (candidates.size() > 0 && beaten) begin
      front = candidates[candidates.size()-1].value;
      beaten = minimum_mode ? (s <= front) : (s >= front);
      if (beaten) void'(candidates.pop_back());
    end
    candidates.push_back('{value: s, position: next_position});
    age = next_position - candidates[0].position;
    while (candidates.size() > 1 && age >= span) begin
      void'(candidates.pop_front());
      age = next_position - candidates[0].position;
    end
    front = candidates[0].value;
    if (eos) begin
      candidates.delete();
      next_position = '0;
    end else begin
      next_position = next_position + POS_W'(1);
    end
    return front;
  endfunction

  // the bench process sits just after a rising edge between these tasks
  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_idle();
    pause_input(1);
    while (awaited_extremes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_item(input logic signed [SW-1:0] s, input logic eos,
                           input bit known, input logic signed [SW-1:0] typed);
    window_result_t due;
    @(negedge clk);
    in_valid  = 1'b1;
    in_sample = s;
    in_eos    = eos;
    do @(posedge clk); while (!in_ready);
    due.extreme = track_extreme(s, eos);
    if (known) due.extreme = typed;
    due.last = eos;
    awaited_extremes.push_back(due);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_WINDOW_LENGTH) window_setting = data[WLEN_W-1:0];
    else if (index == REG_FIND_MINIMUM) minimum_mode = data[0];
    @(negedge clk);
    cfg_valid = 1'b0;
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (steady_drain) begin
      out_ready <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
        stall_left    = $urandom_range(8, 120);
      end
      out_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      stall_left--;
    end
  end

  always @(posedge clk) begin : check_results
    window_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_extremes.size() == 0) begin
        $error("result with no item pending: window_extreme=%0d last_out=%0b",
               window_extreme, last_out);
        mismatch_count++;
      end else begin
        due = awaited_extremes.pop_front();
        if (window_extreme !== due.extreme) begin
          $error("window_extreme: expected %0d, got %0d", due.extreme, window_extreme);
          mismatch_count++;
        end
        if (last_out !== due.last) begin
          $error("last_out: expected %0b, got %0b", due.last, last_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int                   random_items;
    int                   phase;
    int                   phase_len;
    int                   style;
    int                   burst_left;
    int                   seq_left;
    int                   hold_at;
    int                   ramp_step;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] ramp_value;
    logic                 eos;

    random_items = 0;
    phase        = 0;
    seq_left     = 0;
    ramp_value   = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_item(directed_rows[i].sample, directed_rows[i].eos,
                  directed_rows[i].known, directed_rows[i].extreme);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      if (phase < 5 || $urandom_range(0, 2) == 0) begin
        write_reg(REG_WINDOW_LENGTH, (phase < 5) ? length_extremes[phase] : 8'($urandom()));
        write_reg(REG_FIND_MINIMUM, 8'($urandom()));
        if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, 8'($urandom()));
      end else if ($urandom_range(0, 3) == 0) begin
        // drain everything before going on
        wait_idle();
      end
      style      = $urandom_range(0, 3);
      phase_len  = $urandom_range(40, 160);
      burst_left = ($urandom_range(0, 4) == 0) ? phase_len : 0;
      hold_at    = (phase % 6 == 2) ? $urandom_range(5, 30) : -1;
      ramp_step  = int'($urandom_range(0, 6)) - 3;
      for (int k = 0; k < phase_len; k++) begin
        if (k == hold_at) hold_req = 1'b1;
        if (burst_left == 0) begin
          pause_input($urandom_range(1, 12));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        case (style)
          0: s = SW'($urandom());
          1: s = SW'(int'($urandom_range(0, 6)) - 3);  // many ties
          2: begin
            ramp_value = ramp_value + SW'(ramp_step);
            if ($urandom_range(0, 15) == 0) s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            else s = ramp_value;
          end
          default: begin
            case ($urandom_range(0, 3))
              0: s = SAMPLE_MIN;
              1: s = SAMPLE_MAX;
              2: s = '0;
              default: s = -16'sd1;
            endcase
          end
        endcase
        if (seq_left == 0) begin
          seq_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
        end
        seq_left--;
        eos = (seq_left == 0) || ($urandom_range(0, 49) == 0);
        if (eos) seq_left = 0;
        send_item(s, eos, 1'b0, '0);
        random_items++;
      end
      phase++;
    end

    // one long sequence at the widest window with a steady drain
    write_reg(REG_WINDOW_LENGTH, 8'd16);
    write_reg(REG_FIND_MINIMUM, 8'h00);
    steady_drain = 1'b1;
    for (int i = 0; i < LONG_ITEMS; i++) begin
      s = ($urandom_range(0, 7) == 0) ? SW'($urandom()) : SW'(-i);
      send_item(s, i == LONG_ITEMS - 1, 1'b0, '0);
    end
    steady_drain = 1'b0;

    pause_input(1);
    for (int t = 0; t < 5000 && awaited_extremes.size() != 0; t++) @(posedge clk);
    if (awaited_extremes.size() != 0) begin
      $error("%0d results never arrived", awaited_extremes.size());
      mismatch_count++;
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
